// File: rtl/fqp_pkg.sv
// Shared types and constants for the FASTQ record parser.
// Holds the default limits, steering characters, parse phases, result kinds,
// error codes and the result beat type. No dependencies.
`timescale 1ns / 1ps

package fqp_pkg;

    // Default limits on description and sequence length.
    localparam int DEF_MAX_DESC = 256;
    localparam int DEF_MAX_SEQ  = 65536;

    // Width of the record length field on the result channel.
    localparam int REC_LEN_W = 17;

    // Characters that steer the parse.
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Parse phase of the current record.
    typedef enum logic [2:0] {
        PH_HDR_START = 3'd0,
        PH_HDR_DESC  = 3'd1,
        PH_SEQ       = 3'd2,
        PH_PLUS      = 3'd3,
        PH_QUAL      = 3'd4,
        PH_QUAL_END  = 3'd5,
        PH_HALT      = 3'd6,
        PH_DONE      = 3'd7
    } phase_t;

    // Kind of a result beat.
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_DESC    = 3'd1,
        KIND_SEQ     = 3'd2,
        KIND_QUAL    = 3'd3,
        KIND_REC_END = 3'd4,
        KIND_ERROR   = 3'd5,
        KIND_DONE    = 3'd6
    } kind_t;

    // Error codes carried with an error beat.
    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_BAD_START     = 3'd1,
        ERR_EMPTY_SEQ     = 3'd2,
        ERR_PREMATURE_END = 3'd3,
        ERR_DESC_MISMATCH = 3'd4,
        ERR_NO_NEWLINE    = 3'd5,
        ERR_TOO_LONG      = 3'd6
    } err_t;

    // One result beat.
    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data_byte;
        err_t                   error_code;
        logic [REC_LEN_W-1:0]   record_length;
    } fqp_result_t;

endpackage

// File: rtl/fqp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the stored header description. No dependencies.
`timescale 1ns / 1ps

module fqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fqp_parser.sv
// Record parse state and the per-beat decision logic of the FASTQ parser.
// Depends on fqp_pkg and fqp_ram (the stored header description).
`timescale 1ns / 1ps

module fqp_parser #(
    parameter int MAX_DESC = fqp_pkg::DEF_MAX_DESC,
    parameter int MAX_SEQ  = fqp_pkg::DEF_MAX_SEQ
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                end_of_input,
    input  logic                relax_desc_check,
    output fqp_pkg::fqp_result_t result
);

    import fqp_pkg::*;

    localparam int DESC_AW    = $clog2(MAX_DESC);
    localparam int DESC_CNT_W = $clog2(MAX_DESC + 1);
    localparam int SEQ_CNT_W  = $clog2(MAX_SEQ + 1);

    phase_t                 phase_reg, phase_next;
    logic [DESC_CNT_W-1:0]  desc_length_reg, desc_length_next;
    logic [DESC_CNT_W-1:0]  compare_index_reg, compare_index_next;
    logic                   desc_mismatch_reg, desc_mismatch_next;
    logic [SEQ_CNT_W-1:0]   seq_count_reg, seq_count_next;
    logic [SEQ_CNT_W-1:0]   qual_count_reg, qual_count_next;
    logic [SEQ_CNT_W-1:0]   qual_inc;

    logic                   ram_we;
    logic [7:0]             ram_rdata;
    logic                   byte_differs;

    // Description store. The read address follows the next compare index, so the
    // byte for the current index is already registered when the next beat arrives.
    fqp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DESC)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (desc_length_reg[DESC_AW-1:0]),
        .wdata (in_byte),
        .raddr (compare_index_next[DESC_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Plus-line byte check against the stored description.
    assign byte_differs = (compare_index_reg >= desc_length_reg)
                       || (compare_index_reg >= DESC_CNT_W'(MAX_DESC))
                       || (ram_rdata != in_byte);

    assign qual_inc = qual_count_reg + SEQ_CNT_W'(1);

    // Next state and result for the beat on the input.
    always_comb
    begin
        phase_next         = phase_reg;
        desc_length_next   = desc_length_reg;
        compare_index_next = compare_index_reg;
        desc_mismatch_next = desc_mismatch_reg;
        seq_count_next     = seq_count_reg;
        qual_count_next    = qual_count_reg;
        ram_we             = 1'b0;
        result             = '0;
        result.kind        = KIND_NONE;
        result.error_code  = ERR_NONE;

        if (accept && phase_reg != PH_HALT && phase_reg != PH_DONE)
        begin
            if (end_of_input)
            begin
                if (phase_reg == PH_HDR_START)
                begin
                    phase_next  = PH_DONE;
                    result.kind = KIND_DONE;
                end
                else
                begin
                    phase_next        = PH_HALT;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_PREMATURE_END;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HDR_START:
                    begin
                        if (in_byte != CH_AT)
                        begin
                            phase_next        = PH_HALT;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_BAD_START;
                        end
                        else
                        begin
                            desc_length_next = '0;
                            phase_next       = PH_HDR_DESC;
                        end
                    end
                    PH_HDR_DESC:
                    begin
                        if (in_byte == CH_NL)
                        begin
                            seq_count_next = '0;
                            phase_next     = PH_SEQ;
                        end
                        else if (desc_length_reg >= DESC_CNT_W'(MAX_DESC))
                        begin
                            phase_next        = PH_HALT;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_TOO_LONG;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            desc_length_next = desc_length_reg + DESC_CNT_W'(1);
                            result.kind      = KIND_DESC;
                            result.data_byte = in_byte;
                        end
                    end
                    PH_SEQ:
                    begin
                        if (in_byte == CH_PLUS)
                        begin
                            if (seq_count_reg == '0)
                            begin
                                phase_next        = PH_HALT;
                                result.kind       = KIND_ERROR;
                                result.error_code = ERR_EMPTY_SEQ;
                            end
                            else
                            begin
                                compare_index_next = '0;
                                desc_mismatch_next = 1'b0;
                                phase_next         = PH_PLUS;
                            end
                        end
                        else if (in_byte == CH_NL || in_byte == CH_SPACE)
                        begin
                            // Line breaks and spaces inside the sequence are dropped.
                        end
                        else if (seq_count_reg >= SEQ_CNT_W'(MAX_SEQ))
                        begin
                            phase_next        = PH_HALT;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_TOO_LONG;
                        end
                        else
                        begin
                            seq_count_next   = seq_count_reg + SEQ_CNT_W'(1);
                            result.kind      = KIND_SEQ;
                            result.data_byte = in_byte;
                        end
                    end
                    PH_PLUS:
                    begin
                        if (in_byte == CH_NL)
                        begin
                            // An empty plus line always passes.
                            if (!relax_desc_check && compare_index_reg != '0
                                && (desc_mismatch_reg
                                    || compare_index_reg != desc_length_reg))
                            begin
                                phase_next        = PH_HALT;
                                result.kind       = KIND_ERROR;
                                result.error_code = ERR_DESC_MISMATCH;
                            end
                            else
                            begin
                                qual_count_next = '0;
                                phase_next      = PH_QUAL;
                            end
                        end
                        else
                        begin
                            if (byte_differs)
                            begin
                                desc_mismatch_next = 1'b1;
                            end
                            // The index stops at the store depth.
                            if (compare_index_reg < DESC_CNT_W'(MAX_DESC))
                            begin
                                compare_index_next = compare_index_reg + DESC_CNT_W'(1);
                            end
                        end
                    end
                    PH_QUAL:
                    begin
                        if (in_byte != CH_NL && in_byte != CH_SPACE)
                        begin
                            qual_count_next  = qual_inc;
                            if (qual_inc >= seq_count_reg)
                            begin
                                phase_next = PH_QUAL_END;
                            end
                            result.kind      = KIND_QUAL;
                            result.data_byte = in_byte;
                        end
                    end
                    PH_QUAL_END:
                    begin
                        if (in_byte != CH_NL)
                        begin
                            phase_next        = PH_HALT;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_NO_NEWLINE;
                        end
                        else
                        begin
                            phase_next           = PH_HDR_START;
                            result.kind          = KIND_REC_END;
                            result.record_length = REC_LEN_W'(seq_count_reg);
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HDR_START;
            desc_length_reg   <= '0;
            compare_index_reg <= '0;
            desc_mismatch_reg <= 1'b0;
            seq_count_reg     <= '0;
            qual_count_reg    <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            desc_length_reg   <= desc_length_next;
            compare_index_reg <= compare_index_next;
            desc_mismatch_reg <= desc_mismatch_next;
            seq_count_reg     <= seq_count_next;
            qual_count_reg    <= qual_count_next;
        end
    end

endmodule

// File: rtl/fqp_out_stage.sv
// Result register of the FASTQ parser, holding one beat for the receiver.
// Depends on fqp_pkg for the result beat type.
`timescale 1ns / 1ps

module fqp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  fqp_pkg::fqp_result_t result,
    input  logic                 out_ready,
    output logic                 out_valid,
    output fqp_pkg::fqp_result_t out_beat,
    output logic                 can_load
);

    import fqp_pkg::*;

    logic        valid_reg;
    fqp_result_t beat_reg;

    // A new beat may enter when the register is empty or is being drained.
    assign can_load = !valid_reg || out_ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: rtl/fastq_record_parser_core.sv
// Top level of the FASTQ record parser: stream ports, configuration register.
// Depends on fqp_pkg, fqp_parser and fqp_out_stage.
`timescale 1ns / 1ps

// Usage
// The input stream carries one text byte per beat in s_tdata; s_tuser flags the
// end of input, in which case the byte is ignored. Every accepted input beat
// produces exactly one result beat on the m_ side, whose kind in m_tuser says
// whether it carries a description, sequence or quality byte, a record end with
// the sequence length, an error code, completion, or nothing.
// The result of an accepted beat is registered and presented from the next
// edge. One beat is taken per cycle while the receiver accepts results. The
// plus-line compare reads the stored description through the registered read
// port of its RAM, addressed one beat ahead, so the compare adds no stall.
// When the receiver stalls, the pending result stays in the output register and
// a further input beat is accepted in the same cycle that the pending one drains.
// Reset clears the parse state to expect a header and empties the output. The
// description store needs no clearing, as only written entries are compared.
// After an error or completion every beat yields kind nothing until reset.
// cfg_we writes cfg_wdata into the relax-description-check register; write it
// only while the block is idle.

module fastq_record_parser_core #(
    parameter int MAX_DESC = fqp_pkg::DEF_MAX_DESC,
    parameter int MAX_SEQ  = fqp_pkg::DEF_MAX_SEQ
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,   // relax_desc_check
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // in_byte
    input  logic [0:0]  s_tuser,     // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // data_byte[7:0], error_code[10:8],
                                     // record_length[27:11], zero fill
    output logic [2:0]  m_tuser      // kind
);

    import fqp_pkg::*;

    logic        relax_reg;
    logic        accept;
    fqp_result_t step_result;
    fqp_result_t out_beat;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            relax_reg <= cfg_wdata[0];
        end
    end

    assign accept = s_tvalid && s_tready;

    // Per-beat parse logic.
    fqp_parser #(
        .MAX_DESC (MAX_DESC),
        .MAX_SEQ  (MAX_SEQ)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .in_byte          (s_tdata),
        .end_of_input     (s_tuser[0]),
        .relax_desc_check (relax_reg),
        .result           (step_result)
    );

    // Result register towards the receiver.
    fqp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (step_result),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_beat  (out_beat),
        .can_load  (s_tready)
    );

    // Pack the result beat onto the output ports.
    assign m_tuser = out_beat.kind;
    assign m_tdata = {4'b0000, out_beat.record_length, out_beat.error_code,
                      out_beat.data_byte};

`ifndef ASSERT_OFF
    // With the output register empty the block must take input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while the output register is empty");

    // Every accepted input beat presents a result at the next edge.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");

    // An error beat always carries a code, and no other kind does.
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[10:8] != ERR_NONE)))
        else $error("error code does not match result kind");
`endif

endmodule
